// ----- rtl/rpcg_pkg.sv -----
// Shared types and constants of the random password character generator.
package rpcg_pkg;

    localparam int WORD_W      = 16;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CHAR_W      = 7;
    localparam int POS_W       = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PASSWORD_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPITAL_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT     = 2'd2;

    localparam logic [CFG_W-1:0] RST_PASSWORD_LENGTH = 7'd16;
    localparam logic [CFG_W-1:0] RST_CAPITAL_COUNT   = 7'd1;
    localparam logic [CFG_W-1:0] RST_DIGIT_COUNT     = 7'd1;

    localparam logic [POS_W-1:0]  ALPHA_MOD    = 8'd26;
    localparam logic [POS_W-1:0]  DIGIT_MOD    = 8'd10;
    localparam logic [CHAR_W-1:0] BASE_LOWER   = 7'h61;
    localparam logic [CHAR_W-1:0] BASE_CAPITAL = 7'h41;
    localparam logic [CHAR_W-1:0] BASE_DIGIT   = 7'h30;

    localparam logic [WORD_W-1:0] ALPHA_RECIP = 16'd40330;
    localparam int                ALPHA_SHIFT = 20;
    localparam logic [WORD_W-1:0] DIGIT_RECIP = 16'd52429;
    localparam int                DIGIT_SHIFT = 19;

    typedef enum logic [1:0] {
        KIND_LOWER   = 2'd0,
        KIND_CAPITAL = 2'd1,
        KIND_DIGIT   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PLACE = 2'd1,
        PH_EMIT  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        BK_IDLE   = 3'd0,
        BK_READ   = 3'd1,
        BK_START  = 3'd2,
        BK_DIVIDE = 3'd3,
        BK_APPLY  = 3'd4,
        BK_EMIT   = 3'd5
    } t_back_state;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              place;
        logic              new_pw;
        logic              capital;
        logic [POS_W-1:0]  divisor;
        logic [POS_W-1:0]  last_idx;
        logic [POS_W-1:0]  pos;
        logic              last;
    } t_cmd;

endpackage

// ----- rtl/random_password_char_generator_top.sv -----
// Top level of the random password character generator.
// A character request taken by an idle back end passes through READ and EMIT before its
// result is strobed. The back end pops one request at a time, only from idle; a placement
// request strobes nothing and holds the back end for the 16-step remainder by pool size.
// Reset: synchronous, active low; config returns to 16/1/1, no table clearing pass.
// Results are strobed for one cycle and cannot be stalled by the receiver.
module random_password_char_generator_top #(
    parameter int MAX_LEN = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rpcg_pkg::WORD_W-1:0]    i_random_word,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rpcg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rpcg_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_valid,
    output logic [rpcg_pkg::CHAR_W-1:0]    o_character,
    output logic                          o_last_of_password
);
    import rpcg_pkg::*;

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic accept;

    assign busy        = q_full;
    assign accept      = start && !q_full;
    assign o_cfg_ready = 1'b1;

    rpcg_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_random_word (i_random_word),
        .o_cmd         (front_cmd)
    );

    rpcg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (head_cmd),
        .o_empty (q_empty)
    );

    rpcg_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last_of_password)
    );

endmodule

// ----- rtl/rpcg_queue.sv -----
// Two-entry command queue between the front end and the back end.
module rpcg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rpcg_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output rpcg_pkg::t_cmd o_data,
    output logic          o_empty
);
    import rpcg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/rpcg_divider.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module rpcg_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rpcg_pkg::WORD_W-1:0] i_dividend,
    input  logic [rpcg_pkg::POS_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [rpcg_pkg::POS_W-1:0]  o_rem
);
    import rpcg_pkg::*;

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_word;
    logic [POS_W-1:0]  r_div;
    logic [POS_W-1:0]  r_rem;
    logic [POS_W:0]    trial;
    logic              fits;

    assign trial  = {r_rem, r_word[WORD_W-1]};
    assign fits   = (trial >= {1'b0, r_div});
    assign o_done = r_done;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_word <= i_dividend;
            r_div  <= i_divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_word <= {r_word[WORD_W-2:0], 1'b0};
            r_rem  <= fits ? POS_W'(trial - {1'b0, r_div}) : POS_W'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WORD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

// ----- rtl/rpcg_front.sv -----
// Front end: configuration registers, password sequencing and command issue.
module rpcg_front #(
    parameter int MAX_LEN = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [rpcg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rpcg_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_accept,
    input  logic [rpcg_pkg::WORD_W-1:0]    i_random_word,
    output rpcg_pkg::t_cmd                 o_cmd
);
    import rpcg_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int EW = ((LW > CFG_W) ? LW : CFG_W) + 1;

    logic [CFG_W-1:0] r_cfg_len;
    logic [CFG_W-1:0] r_cfg_caps;
    logic [CFG_W-1:0] r_cfg_digs;

    t_phase        r_phase, n_phase;
    logic [LW-1:0] r_step, n_step;
    logic [LW-1:0] r_rem, n_rem;
    logic [LW-1:0] r_caps, n_caps;
    logic [LW-1:0] r_cd, n_cd;
    logic [LW-1:0] r_len, n_len;

    logic [EW-1:0] max_e;
    logic [EW-1:0] caps_e;
    logic [EW-1:0] digs_e;
    logic [EW-1:0] len_e;
    logic [EW-1:0] eff_c;
    logic [EW-1:0] dmax;
    logic [EW-1:0] eff_d;
    logic [EW-1:0] req_n;
    logic [EW-1:0] clip_n;
    logic [EW-1:0] eff_cd;
    logic [EW-1:0] eff_l;

    logic          cur_place;
    logic          cur_new;
    logic [LW-1:0] cur_step;
    logic [LW-1:0] cur_rem;
    logic [LW-1:0] cur_caps;
    logic [LW-1:0] cur_cd;
    logic [LW-1:0] cur_len;
    logic [LW:0]   step_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len  <= RST_PASSWORD_LENGTH;
            r_cfg_caps <= RST_CAPITAL_COUNT;
            r_cfg_digs <= RST_DIGIT_COUNT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PASSWORD_LENGTH: r_cfg_len  <= i_cfg_data;
                CFG_CAPITAL_COUNT:   r_cfg_caps <= i_cfg_data;
                CFG_DIGIT_COUNT:     r_cfg_digs <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_step  <= '0;
            r_rem   <= '0;
            r_caps  <= '0;
            r_cd    <= '0;
            r_len   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_rem   <= n_rem;
            r_caps  <= n_caps;
            r_cd    <= n_cd;
            r_len   <= n_len;
        end
    end

    always_comb begin
        max_e  = EW'(MAX_LEN);
        caps_e = EW'(r_cfg_caps);
        digs_e = EW'(r_cfg_digs);
        len_e  = EW'(r_cfg_len);
        eff_c  = (caps_e > max_e) ? max_e : caps_e;
        dmax   = max_e - eff_c;
        eff_d  = (digs_e > dmax) ? dmax : digs_e;
        req_n  = (len_e == '0) ? EW'(1) : len_e;
        clip_n = (req_n > max_e) ? max_e : req_n;
        eff_cd = eff_c + eff_d;
        eff_l  = (eff_cd > clip_n) ? eff_cd : clip_n;

        if (r_phase == PH_IDLE) begin
            cur_new   = 1'b1;
            cur_place = (eff_cd != '0);
            cur_step  = '0;
            cur_rem   = LW'(eff_l);
            cur_caps  = LW'(eff_c);
            cur_cd    = LW'(eff_cd);
            cur_len   = LW'(eff_l);
        end else begin
            cur_new   = 1'b0;
            cur_place = (r_phase == PH_PLACE);
            cur_step  = r_step;
            cur_rem   = r_rem;
            cur_caps  = r_caps;
            cur_cd    = r_cd;
            cur_len   = r_len;
        end

        step_inc = {1'b0, cur_step} + 1'b1;

        o_cmd.word     = i_random_word;
        o_cmd.place    = cur_place;
        o_cmd.new_pw   = cur_new;
        o_cmd.capital  = (cur_step < cur_caps);
        o_cmd.divisor  = POS_W'(cur_rem);
        o_cmd.last_idx = POS_W'(cur_rem - 1'b1);
        o_cmd.pos      = POS_W'(cur_step);
        o_cmd.last     = (step_inc >= {1'b0, cur_len});

        n_caps = cur_caps;
        n_cd   = cur_cd;
        n_len  = cur_len;
        n_rem  = cur_rem;
        if (cur_place) begin
            n_rem = cur_rem - 1'b1;
            if (step_inc >= {1'b0, cur_cd}) begin
                n_phase = PH_EMIT;
                n_step  = '0;
            end else begin
                n_phase = PH_PLACE;
                n_step  = LW'(step_inc);
            end
        end else if (o_cmd.last) begin
            n_phase = PH_IDLE;
            n_step  = '0;
        end else begin
            n_phase = PH_EMIT;
            n_step  = LW'(step_inc);
        end
    end

endmodule

// ----- rtl/rpcg_back.sv -----
// Back end: position sampling, kind table and character generation.
module rpcg_back #(
    parameter int MAX_LEN = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rpcg_pkg::t_cmd              i_cmd,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_valid,
    output logic [rpcg_pkg::CHAR_W-1:0] o_character,
    output logic                       o_last
);
    import rpcg_pkg::*;

    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    t_back_state r_state, n_state;
    t_cmd        r_cmd;
    logic [IW-1:0] r_rpos;

    logic [IW-1:0]      r_pool_mem [MAX_LEN];
    logic [MAX_LEN-1:0] r_pool_vld;
    logic [1:0]         r_kind_mem [MAX_LEN];
    logic [MAX_LEN-1:0] r_kind_vld;

    logic [IW-1:0] r_pool_a;
    logic [IW-1:0] r_pool_b;
    logic          r_pvld_a;
    logic          r_pvld_b;
    logic [1:0]    r_kind_rd;
    logic          r_kvld_rd;

    logic [WORD_W-1:0] r_quo_alpha;
    logic [WORD_W-1:0] r_quo_digit;

    logic              r_out_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    t_kind            cur_kind;
    logic             div_start;
    logic             div_done;
    logic [POS_W-1:0] div_rem;
    logic [IW-1:0]    last_addr;
    logic [IW-1:0]    pos_addr;
    logic [IW-1:0]    sel_pos;
    logic [IW-1:0]    moved;
    logic [CHAR_W-1:0] base;
    logic [CHAR_W-1:0] offset;

    logic [2*WORD_W-1:0] prod_alpha;
    logic [2*WORD_W-1:0] prod_digit;
    logic [WORD_W-1:0]   rem_alpha;
    logic [WORD_W-1:0]   rem_digit;

    rpcg_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_cmd.word),
        .i_divisor  (r_cmd.divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign last_addr   = r_cmd.last_idx[IW-1:0];
    assign pos_addr    = r_cmd.pos[IW-1:0];
    assign sel_pos     = r_pvld_a ? r_pool_a : r_rpos;
    assign moved       = r_pvld_b ? r_pool_b : last_addr;
    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    assign prod_alpha = r_cmd.word * ALPHA_RECIP;
    assign prod_digit = r_cmd.word * DIGIT_RECIP;
    assign rem_alpha  = r_cmd.word - WORD_W'(r_quo_alpha * WORD_W'(ALPHA_MOD));
    assign rem_digit  = r_cmd.word - WORD_W'(r_quo_digit * WORD_W'(DIGIT_MOD));

    always_comb begin
        if (!r_kvld_rd) begin
            cur_kind = KIND_LOWER;
        end else begin
            case (r_kind_rd)
                KIND_CAPITAL: cur_kind = KIND_CAPITAL;
                KIND_DIGIT:   cur_kind = KIND_DIGIT;
                default:      cur_kind = KIND_LOWER;
            endcase
        end
        case (cur_kind)
            KIND_CAPITAL: begin
                base   = BASE_CAPITAL;
                offset = rem_alpha[CHAR_W-1:0];
            end
            KIND_DIGIT: begin
                base   = BASE_DIGIT;
                offset = rem_digit[CHAR_W-1:0];
            end
            default: begin
                base   = BASE_LOWER;
                offset = rem_alpha[CHAR_W-1:0];
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        div_start = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = i_cmd.place ? BK_START : BK_READ;
                end
            end
            BK_READ: begin
                n_state = r_cmd.place ? BK_APPLY : BK_EMIT;
            end
            BK_START: begin
                div_start = 1'b1;
                n_state   = BK_DIVIDE;
            end
            BK_DIVIDE: begin
                if (div_done) begin
                    n_state = BK_READ;
                end
            end
            BK_APPLY: begin
                n_state = BK_IDLE;
            end
            BK_EMIT: begin
                n_state = BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == BK_DIVIDE && div_done) begin
            r_rpos <= div_rem[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_READ) begin
            r_quo_alpha <= WORD_W'(prod_alpha >> ALPHA_SHIFT);
            r_quo_digit <= WORD_W'(prod_digit >> DIGIT_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_READ) begin
            r_pool_a  <= r_pool_mem[r_rpos];
            r_pool_b  <= r_pool_mem[last_addr];
            r_pvld_a  <= r_pool_vld[r_rpos];
            r_pvld_b  <= r_pool_vld[last_addr];
            r_kind_rd <= r_kind_mem[pos_addr];
            r_kvld_rd <= r_kind_vld[pos_addr];
        end
        if (r_state == BK_APPLY) begin
            r_pool_mem[r_rpos]  <= moved;
            r_kind_mem[sel_pos] <= r_cmd.capital ? KIND_CAPITAL : KIND_DIGIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_vld <= '0;
            r_kind_vld <= '0;
        end else if (o_pop && i_cmd.new_pw) begin
            r_pool_vld <= '0;
            r_kind_vld <= '0;
        end else if (r_state == BK_APPLY) begin
            r_pool_vld[r_rpos]  <= 1'b1;
            r_kind_vld[sel_pos] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_state == BK_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_EMIT) begin
            r_char <= base + offset;
            r_last <= r_cmd.last;
        end
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the random password character generator top level.
module tb;
    import rpcg_pkg::*;

    localparam int MAX_LEN    = 64;
    localparam int SETTLE     = 120;
    localparam int LIMIT      = 400000;
    localparam int ITEMS      = 800;
    localparam int QUIET_FROM = 650;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char;

    class password_scoreboard;
        logic [CFG_W-1:0] length_reg;
        logic [CFG_W-1:0] caps_reg;
        logic [CFG_W-1:0] digits_reg;
        logic [POS_W-1:0] pool [MAX_LEN];
        t_kind            kinds [MAX_LEN];
        t_phase           phase;
        int unsigned      step;
        int unsigned      remaining;
        int unsigned      pw_len;
        int unsigned      pw_caps;
        int unsigned      pw_digits;
        t_char            expected_chars [$];
        int               errors;

        function new();
            length_reg = RST_PASSWORD_LENGTH;
            caps_reg   = RST_CAPITAL_COUNT;
            digits_reg = RST_DIGIT_COUNT;
            phase      = PH_IDLE;
            step       = 0;
            remaining  = 0;
            pw_len     = 0;
            pw_caps    = 0;
            pw_digits  = 0;
            errors     = 0;
            foreach (pool[i]) begin
                pool[i]  = '0;
                kinds[i] = KIND_LOWER;
            end
        endfunction

        function void write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_PASSWORD_LENGTH: length_reg = data;
                CFG_CAPITAL_COUNT:   caps_reg   = data;
                CFG_DIGIT_COUNT:     digits_reg = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void begin_password();
            int unsigned c, d, n;
            c = (caps_reg > MAX_LEN) ? MAX_LEN : caps_reg;
            d = (digits_reg > MAX_LEN - c) ? MAX_LEN - c : digits_reg;
            n = (length_reg == 0) ? 1 : length_reg;
            if (n > MAX_LEN)
                n = MAX_LEN;
            if (c + d > n)
                n = c + d;
            pw_len    = n;
            pw_caps   = c;
            pw_digits = d;
            for (int i = 0; i < MAX_LEN; i++) begin
                pool[i]  = POS_W'(i);
                kinds[i] = KIND_LOWER;
            end
            remaining = n;
            step      = 0;
            if (c + d > 0)
                phase = PH_PLACE;
            else
                phase = PH_EMIT;
        endfunction

        function void place_position(logic [WORD_W-1:0] w);
            int unsigned r, top, sel;
            r   = 0;
            top = 0;
            if (remaining > 0 && remaining <= MAX_LEN) begin
                r   = w % remaining;
                top = remaining - 1;
            end
            sel     = pool[r] % MAX_LEN;
            pool[r] = pool[top];
            if (step < pw_caps)
                kinds[sel] = KIND_CAPITAL;
            else
                kinds[sel] = KIND_DIGIT;
            if (remaining > 0)
                remaining--;
            step++;
            if (step >= pw_caps + pw_digits) begin
                phase = PH_EMIT;
                step  = 0;
            end
        endfunction

        function void emit_char(logic [WORD_W-1:0] w);
            t_char c;
            case (kinds[step % MAX_LEN])
                KIND_CAPITAL: c.code = BASE_CAPITAL + CHAR_W'(w % ALPHA_MOD);
                KIND_DIGIT:   c.code = BASE_DIGIT + CHAR_W'(w % DIGIT_MOD);
                default:      c.code = BASE_LOWER + CHAR_W'(w % ALPHA_MOD);
            endcase
            c.last = (step + 1 >= pw_len);
            expected_chars.push_back(c);
            if (c.last) begin
                phase = PH_IDLE;
                step  = 0;
            end else begin
                step++;
            end
        endfunction

        function void note_word(logic [WORD_W-1:0] w);
            if (phase != PH_PLACE && phase != PH_EMIT)
                begin_password();
            if (phase == PH_PLACE)
                place_position(w);
            else
                emit_char(w);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_char(logic [CHAR_W-1:0] code, logic last);
            t_char e;
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected character 0x%02h last %0b", code, last));
            end else begin
                e = expected_chars.pop_front();
                if (code !== e.code)
                    report($sformatf("character 0x%02h, want 0x%02h", code, e.code));
                if (last !== e.last)
                    report($sformatf("last_of_password %0b, want %0b", last, e.last));
            end
        endtask
    endclass

    logic                 i_clk              = 1'b0;
    logic                 i_rst_n            = 1'b0;
    logic                 start              = 1'b0;
    logic [WORD_W-1:0]    i_random_word      = '0;
    logic                 i_cfg_valid        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index        = '0;
    logic [CFG_W-1:0]     i_cfg_data         = '0;
    logic                 busy;
    logic                 o_cfg_ready;
    logic                 o_valid;
    logic [CHAR_W-1:0]    o_character;
    logic                 o_last_of_password;

    password_scoreboard sb = new();
    int                 items_sent = 0;
    int                 cycles     = 0;

    random_password_char_generator_top #(.MAX_LEN(MAX_LEN)) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_random_word      (i_random_word),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .o_character        (o_character),
        .o_last_of_password (o_last_of_password)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_char(o_character, o_last_of_password);
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return WORD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] w);
        start         <= 1'b1;
        i_random_word <= w;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sb.note_word(w);
        items_sent++;
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 15))
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.write_config(idx, data);
    endtask

    task automatic program_settings(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] caps,
                                    input logic [CFG_W-1:0] digs);
        write_reg(CFG_PASSWORD_LENGTH, len);
        write_reg(CFG_UNUSED, CFG_W'($urandom_range(0, 127)));
        write_reg(CFG_CAPITAL_COUNT, caps);
        write_reg(CFG_DIGIT_COUNT, digs);
        i_cfg_valid <= 1'b0;
    endtask

    // hold off until every character is out and the back end has gone quiet
    task automatic wait_idle();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int count, input bit gaps);
        for (int i = 0; i < count; i++) begin
            send_word(pick_word());
            if (gaps && items_sent < QUIET_FROM && $urandom_range(0, 3) == 0)
                idle_burst();
        end
    endtask

    initial begin
        logic [CFG_W-1:0] len, caps, digs;
        repeat (6)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        program_settings(7'd0, 7'd0, 7'd0);
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'd25);
        send_word(16'd26);
        wait_idle();

        program_settings(7'd3, 7'd1, 7'd1);
        send_word(16'd9);
        send_word(16'd10);
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(16'h5555);
        wait_idle();

        program_settings(7'd2, 7'd0, 7'd3);
        send_word(16'h000A);
        send_word(16'h0009);
        send_word(16'hAAAA);
        send_word(16'h8000);
        send_word(16'h7FFF);
        send_word(16'h0001);
        wait_idle();

        // leave a password half done across the next settings change
        program_settings(7'd5, 7'd2, 7'd0);
        send_word(16'h1234);
        send_word(16'hFEDC);
        send_word(16'h0F0F);

        while (items_sent < ITEMS) begin
            wait_idle();
            case ($urandom_range(0, 19))
                0: begin
                    len  = 7'd127;
                    caps = 7'd0;
                    digs = 7'd0;
                end
                1: begin
                    len  = CFG_W'($urandom_range(0, 127));
                    caps = 7'd127;
                    digs = CFG_W'($urandom_range(0, 127));
                end
                2: begin
                    len  = 7'd64;
                    caps = CFG_W'($urandom_range(0, 64));
                    digs = 7'd127;
                end
                3: begin
                    len  = 7'd0;
                    caps = CFG_W'($urandom_range(0, 2));
                    digs = CFG_W'($urandom_range(0, 2));
                end
                default: begin
                    len  = CFG_W'($urandom_range(1, 12));
                    caps = CFG_W'($urandom_range(0, 4));
                    digs = CFG_W'($urandom_range(0, 4));
                end
            endcase
            program_settings(len, caps, digs);
            run_phase($urandom_range(5, 60), $urandom_range(0, 2) != 0);
        end

        wait_idle();
        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
